// ===== rtl/efs_pkg.sv =====
// Package for the edge-follow steering block: payload types, configuration
// registers, state codes and register indexes. No dependencies.
`default_nettype none

package efs_pkg;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_WHITE_REF  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_WHITE_REF = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_SPEED      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_SPEED     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAIGHT_MS     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_MS         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEMORY_MS       = 3'd6;
   localparam int CSR_DATA_W = 16;

   // Last commanded move.
   localparam logic [1:0] MOVE_STRAIGHT = 2'd0;
   localparam logic [1:0] MOVE_LEFT     = 2'd1;
   localparam logic [1:0] MOVE_RIGHT    = 2'd2;

   // Colour seen by the previous sample.
   localparam logic [1:0] COLOUR_EDGE  = 2'd0;
   localparam logic [1:0] COLOUR_WHITE = 2'd1;
   localparam logic [1:0] COLOUR_BLACK = 2'd2;

   // Queue depth between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [11:0] left_sum;
      logic [11:0] right_sum;
      logic [31:0] now_ms;
      logic [31:0] entropy;
   } req_type;

   typedef struct packed {
      logic [7:0] left_drive;
      logic [7:0] right_drive;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  left_white_ref;
      logic [9:0]  right_white_ref;
      logic [7:0]  left_speed;
      logic [7:0]  right_speed;
      logic [15:0] straight_ms;
      logic [15:0] turn_ms;
      logic [15:0] memory_ms;
   } cfg_type;

   // A classified sample as it travels from the front to the back.
   typedef struct packed {
      logic        left_white;
      logic        right_white;
      logic [31:0] now_ms;
      logic [31:0] entropy;
   } item_type;

   // Handshake between the queue and one of its neighbors.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/efs_front.sv =====
// Front stage: accepts a sensor request and classifies each side as white.
// Depends on efs_pkg; pushes classified items into efs_queue.
`default_nettype none

module efs_front import efs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   input  wire cfg_type          cfg,
   input  wire queue_status_type q_status,
   output logic                  push,
   output item_type             push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic [11:0] left_thresh, right_thresh;

   // Three times the white reference, at most 3069, fits in twelve bits.
   assign left_thresh  = {1'b0, cfg.left_white_ref, 1'b0} + {2'b00, cfg.left_white_ref};
   assign right_thresh = {1'b0, cfg.right_white_ref, 1'b0} + {2'b00, cfg.right_white_ref};

   // The stage holds its item only while the queue is full.
   assign push      = valid_ff && !q_status.full;
   assign push_item = item_ff;
   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;

   // Classify the incoming sample.
   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.left_white  = req_data.left_sum > left_thresh;
         item_in.right_white = req_data.right_sum > right_thresh;
         item_in.now_ms      = req_data.now_ms;
         item_in.entropy     = req_data.entropy;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ===== rtl/efs_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on efs_pkg.
`default_nettype none

module efs_queue import efs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire item_type   push_item,
   input  wire logic       pop,
   output queue_status_type status,
   output item_type        head
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign status.valid = count_ff != '0;
   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head         = entry_ff[rd_ptr_ff];
   assign do_pop       = pop && status.valid;

   // Pointer and fill count update; push is only offered when not full.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/efs_back.sv =====
// Back stage: holds the steering state, decides the move for each item and
// registers the motor command. Depends on efs_pkg; fed by efs_queue.
`default_nettype none

module efs_back import efs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire queue_status_type q_status,
   input  wire item_type         head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   logic [1:0]  last_move_ff, last_move_in;
   logic [31:0] move_end_ff, move_end_in;
   logic [31:0] pool_ff, pool_in;
   logic [31:0] memory_end_ff, memory_end_in;
   logic        edge_side_ff, edge_side_in;
   logic [1:0]  last_colour_ff, last_colour_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;

   logic        both_white, one_white;
   logic        memory_open, move_running, toward_edge;
   logic [31:0] pool_eff;
   logic [15:0] duration;
   logic [31:0] move_end_sum, memory_end_sum;
   logic        emit;
   logic [1:0]  move;

   // The item is taken whenever the output register is free or drains.
   assign pop = q_status.valid && (!out_valid_ff || !rsp_stall);

   assign both_white   = head.left_white && head.right_white;
   assign one_white    = head.left_white ^ head.right_white;
   assign memory_open  = head.now_ms < memory_end_ff;
   assign move_running = head.now_ms < move_end_ff;
   assign pool_eff     = (pool_ff == '0) ? head.entropy : pool_ff;
   assign toward_edge  = memory_open ||
                         (both_white ? (last_colour_ff == COLOUR_BLACK)
                                     : (last_colour_ff == COLOUR_WHITE));

   // Choose the move for this sample.
   always_comb begin
      emit = 1'b1;
      move = MOVE_STRAIGHT;
      if (one_white) begin
         move = MOVE_STRAIGHT;
      end else if (toward_edge) begin
         // Turn toward the edge: to black on white, to white on black.
         if (both_white) begin
            move = edge_side_ff ? MOVE_RIGHT : MOVE_LEFT;
         end else begin
            move = edge_side_ff ? MOVE_LEFT : MOVE_RIGHT;
         end
      end else if (move_running) begin
         emit = 1'b0;
      end else if (last_move_ff != MOVE_STRAIGHT) begin
         move = MOVE_STRAIGHT;
      end else begin
         move = pool_eff[0] ? MOVE_LEFT : MOVE_RIGHT;
      end
   end

   // Timers: one add for the move end, one for the edge memory.
   assign duration       = (move == MOVE_STRAIGHT) ? cfg.straight_ms : cfg.turn_ms;
   assign move_end_sum   = head.now_ms + {16'h0000, duration};
   assign memory_end_sum = head.now_ms + {16'h0000, cfg.memory_ms};

   // State update for a popped item.
   always_comb begin
      last_move_in   = last_move_ff;
      move_end_in    = move_end_ff;
      pool_in        = pool_ff;
      memory_end_in  = memory_end_ff;
      edge_side_in   = edge_side_ff;
      last_colour_in = last_colour_ff;
      if (pop) begin
         pool_in = pool_eff;
         if (emit) begin
            last_move_in = move;
            move_end_in  = move_end_sum;
         end
         if (one_white) begin
            memory_end_in  = memory_end_sum;
            edge_side_in   = head.left_white;
            last_colour_in = COLOUR_EDGE;
         end else begin
            last_colour_in = both_white ? COLOUR_WHITE : COLOUR_BLACK;
            // A random-walk turn consumes one bit of the pool.
            if (!toward_edge && emit && move != MOVE_STRAIGHT) begin
               pool_in = {1'b0, pool_eff[31:1]};
            end
         end
      end
   end

   // Output register for the motor command.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (pop) begin
         out_valid_in = emit;
         out_data_in.left_drive  = (move == MOVE_LEFT) ? 8'h00 : cfg.left_speed;
         out_data_in.right_drive = (move == MOVE_RIGHT) ? 8'h00 : cfg.right_speed;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_move_ff   <= MOVE_LEFT;
         move_end_ff    <= '0;
         pool_ff        <= '0;
         memory_end_ff  <= '0;
         edge_side_ff   <= 1'b0;
         last_colour_ff <= COLOUR_WHITE;
         out_valid_ff   <= 1'b0;
      end else begin
         last_move_ff   <= last_move_in;
         move_end_ff    <= move_end_in;
         pool_ff        <= pool_in;
         memory_end_ff  <= memory_end_in;
         edge_side_ff   <= edge_side_in;
         last_colour_ff <= last_colour_in;
         out_valid_ff   <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/edge_follow_steering_top.sv =====
// Edge-follow steering: an accepted request is held in the front register,
// then in a queue entry, then in the back stage's output register (rsp_data).
// Throughput is one request per cycle, set by the back stage's state update,
// when rsp_stall is low; a request that commands no move produces no response.
// Synchronous active-high reset clears the steering state, empties the queue
// and restores every configuration register to its reset value.
`default_nettype none

module edge_follow_steering_top import efs_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             push, pop;
   item_type         push_item, head;

   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEFT_WHITE_REF:  cfg_in.left_white_ref  = csr_wdata[9:0];
            CSR_RIGHT_WHITE_REF: cfg_in.right_white_ref = csr_wdata[9:0];
            CSR_LEFT_SPEED:      cfg_in.left_speed      = csr_wdata[7:0];
            CSR_RIGHT_SPEED:     cfg_in.right_speed     = csr_wdata[7:0];
            CSR_STRAIGHT_MS:     cfg_in.straight_ms     = csr_wdata;
            CSR_TURN_MS:         cfg_in.turn_ms         = csr_wdata;
            CSR_MEMORY_MS:       cfg_in.memory_ms       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_white_ref  <= 10'd512;
         cfg_ff.right_white_ref <= 10'd512;
         cfg_ff.left_speed      <= 8'd17;
         cfg_ff.right_speed     <= 8'd17;
         cfg_ff.straight_ms     <= 16'd300;
         cfg_ff.turn_ms         <= 16'd200;
         cfg_ff.memory_ms       <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   efs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   efs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .status    (q_status),
      .head      (head)
   );

   efs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
